### rtl/bss_pkg.sv
package bss_pkg;

    localparam int DATA_W    = 32;
    localparam int CAP_W     = 7;
    localparam int IDX_OUT_W = 6;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // opcodes; 5..7 are no-ops
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic accept;    // take the request on the input channel
        logic load_out;  // move the pending result into the output register
        logic scan;      // one step of the search walk
    } t_bss_cmd;

    typedef struct packed {
        logic is_search;
        logic scan_done;
        logic out_free;
    } t_bss_sts;

endpackage

### rtl/bounded_stack_with_search_top.sv
// Bounded LIFO stack of signed 32-bit words with a bottom-up linear search.
// Input channel: i_in_valid / o_in_stall carry one request (i_opcode,
//   i_value): push, pop, peek, clear or search. Codes 5..7 do nothing.
// Output channel: o_out_valid / i_out_stall carry one result per request
//   (o_status, o_data, o_found_index, o_count). o_count is the entry count
//   after the request.
// Config channel: i_cfg_valid / o_cfg_ready write the capacity (full
//   limit, saturating at DEPTH). Ready is always high; write only when idle.
// Path: push, pop, peek, clear results pass through the pending-result
//   registers and then the output register. A search walks the entries
//   bottom-up to the lowest match or past the top entry, one memory read and
//   compare a cycle over the single read port; its result then goes the same way.
// Throughput: one non-search request per cycle while the output drains;
//   a search holds o_in_stall high for the length of its walk.
// A result waiting in the output register does not block acceptance of
//   the next request; the next one waits only if the receiver keeps
//   stalling that result or a search is walking.
// Reset (synchronous, active low): count cleared, capacity = 64, output
//   empty. Storage is not cleared and needs no clearing pass.
module bounded_stack_with_search_top #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bss_pkg::CAP_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bss_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [bss_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bss_pkg::STAT_W-1:0]        o_status,
    output logic signed [bss_pkg::DATA_W-1:0] o_data,
    output logic [bss_pkg::IDX_OUT_W-1:0]     o_found_index,
    output logic [bss_pkg::CAP_W-1:0]         o_count
);

    bss_pkg::t_bss_cmd cmd;
    bss_pkg::t_bss_sts sts;

    assign o_cfg_ready = 1'b1;

    bss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bss_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_data        (o_data),
        .o_found_index (o_found_index),
        .o_count       (o_count),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

    // failed or non-read requests never carry data
    a_no_data_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != bss_pkg::STAT_OK) |-> (o_data == '0))
        else $error("data nonzero on failed request");

    // an empty report means the stack really was empty
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == bss_pkg::STAT_EMPTY) |-> (o_count == '0))
        else $error("empty status with nonzero count");

    // a search step and a new request never share a cycle
    a_scan_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan |-> !cmd.accept && !cmd.load_out)
        else $error("search step overlaps accept or output load");

    // a result is loaded only when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("result overwrote a stalled output");

endmodule

### rtl/bss_ctrl.sv
module bss_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bss_pkg::t_bss_sts   i_sts,
    output bss_pkg::t_bss_cmd   o_cmd
);

    bss_pkg::t_state r_state;
    bss_pkg::t_state n_state;
    logic            can_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        can_take = (r_state == bss_pkg::S_IDLE) ||
                   ((r_state == bss_pkg::S_RESP) && i_sts.out_free);
        o_in_stall      = !can_take;
        o_cmd.accept    = i_in_valid && can_take;
        o_cmd.load_out  = (r_state == bss_pkg::S_RESP) && i_sts.out_free;
        o_cmd.scan      = (r_state == bss_pkg::S_SCAN);
        n_state         = r_state;
        case (r_state)
            bss_pkg::S_IDLE: begin
                if (o_cmd.accept) begin
                    n_state = i_sts.is_search ? bss_pkg::S_SCAN : bss_pkg::S_RESP;
                end
            end
            bss_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = bss_pkg::S_RESP;
                end
            end
            bss_pkg::S_RESP: begin
                if (i_sts.out_free) begin
                    if (o_cmd.accept) begin
                        n_state = i_sts.is_search ? bss_pkg::S_SCAN : bss_pkg::S_RESP;
                    end else begin
                        n_state = bss_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = bss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/bss_datapath.sv
module bss_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [bss_pkg::CAP_W-1:0]         i_cfg_data,
    input  logic [bss_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [bss_pkg::DATA_W-1:0] i_value,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [bss_pkg::STAT_W-1:0]        o_status,
    output logic signed [bss_pkg::DATA_W-1:0] o_data,
    output logic [bss_pkg::IDX_OUT_W-1:0]     o_found_index,
    output logic [bss_pkg::CAP_W-1:0]         o_count,
    input  bss_pkg::t_bss_cmd                 i_cmd,
    output bss_pkg::t_bss_sts                 o_sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > bss_pkg::CAP_W) ? CW : bss_pkg::CAP_W;

    logic [bss_pkg::DATA_W-1:0] mem [DEPTH];

    logic [bss_pkg::CAP_W-1:0]  r_capacity;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [bss_pkg::DATA_W-1:0] r_rd_data;
    logic [bss_pkg::DATA_W-1:0] r_key;
    logic [CW-1:0]              r_scan_idx;
    logic [CW-1:0]              r_cmp_idx;
    logic [bss_pkg::STAT_W-1:0] r_res_status;
    logic [CW-1:0]              r_res_idx;
    logic                       r_res_data_en;
    logic                       r_out_valid;

    logic          full;
    logic          empty;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] top_idx;
    logic          cmp_live;
    logic          hit;

    assign o_out_valid = r_out_valid;

    always_comb begin
        full     = (LW'(r_count) >= LW'(r_capacity)) || (r_count >= CW'(DEPTH));
        empty    = (r_count == '0);
        top_idx  = r_count - CW'(1);
        cmp_live = (r_cmp_idx < r_count);
        hit      = cmp_live && (r_rd_data == r_key);
        wr_en    = i_cmd.accept && (i_opcode == bss_pkg::OP_PUSH) && !full;
        rd_en    = 1'b0;
        rd_addr  = r_scan_idx[AW-1:0];
        if (i_cmd.accept) begin
            if ((i_opcode == bss_pkg::OP_POP) || (i_opcode == bss_pkg::OP_PEEK)) begin
                rd_en   = !empty;
                rd_addr = top_idx[AW-1:0];
            end else if (i_opcode == bss_pkg::OP_SEARCH) begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
        end else if (i_cmd.scan) begin
            rd_en = 1'b1;
        end
        n_count = r_count;
        if (i_cmd.accept) begin
            case (i_opcode)
                bss_pkg::OP_PUSH:  if (!full)  n_count = r_count + CW'(1);
                bss_pkg::OP_POP:   if (!empty) n_count = top_idx;
                bss_pkg::OP_CLEAR: n_count = '0;
                default:           n_count = r_count;
            endcase
        end
        o_sts.is_search = (i_opcode == bss_pkg::OP_SEARCH);
        o_sts.scan_done = !cmp_live || hit;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // stack storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= i_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= bss_pkg::CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pending result and search walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key         <= i_value;
            r_res_idx     <= '0;
            r_res_data_en <= 1'b0;
            r_res_status  <= bss_pkg::STAT_OK;
            r_scan_idx    <= CW'(1);
            r_cmp_idx     <= '0;
            case (i_opcode)
                bss_pkg::OP_PUSH: begin
                    if (full) r_res_status <= bss_pkg::STAT_FULL;
                end
                bss_pkg::OP_POP, bss_pkg::OP_PEEK: begin
                    if (empty) r_res_status <= bss_pkg::STAT_EMPTY;
                    else       r_res_data_en <= 1'b1;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.scan) begin
            if (hit) begin
                r_res_status <= bss_pkg::STAT_OK;
                r_res_idx    <= r_cmp_idx;
            end else if (!cmp_live) begin
                r_res_status <= bss_pkg::STAT_NOT_FOUND;
            end else begin
                r_cmp_idx  <= r_scan_idx;
                r_scan_idx <= r_scan_idx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status      <= r_res_status;
            o_data        <= r_res_data_en ? r_rd_data : '0;
            o_found_index <= bss_pkg::IDX_OUT_W'(r_res_idx);
            o_count       <= bss_pkg::CAP_W'(r_count);
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int STACK_DEPTH = 64;
    localparam int SETTLE_CYCLES = 80;      // longest walk is a miss over 64 entries
    localparam int STALL_LIMIT = 4000;      // cycles with no request or result moving
    localparam int HOLDOFF_AT = 300;        // result count that triggers the long hold-off
    localparam int HOLDOFF_CYCLES = 400;

    typedef struct {
        logic [bss_pkg::OP_W-1:0]   op;
        logic [bss_pkg::DATA_W-1:0] value;
    } t_stack_request;

    typedef struct {
        logic [bss_pkg::STAT_W-1:0]    status;
        logic [bss_pkg::DATA_W-1:0]    data;
        logic [bss_pkg::IDX_OUT_W-1:0] found_index;
        logic [bss_pkg::CAP_W-1:0]     count;
    } t_stack_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [bss_pkg::CAP_W-1:0]           i_cfg_data = '0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [bss_pkg::OP_W-1:0]            i_opcode = '0;
    logic signed [bss_pkg::DATA_W-1:0]   i_value = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [bss_pkg::STAT_W-1:0]          o_status;
    logic signed [bss_pkg::DATA_W-1:0]   o_data;
    logic [bss_pkg::IDX_OUT_W-1:0]       o_found_index;
    logic [bss_pkg::CAP_W-1:0]           o_count;

    bounded_stack_with_search_top #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_data       (o_data),
        .o_found_index(o_found_index),
        .o_count      (o_count)
    );

    // Requests waiting to be offered, and results owed by the block in order.
    t_stack_request pending_requests[$];
    t_stack_result  owed_results[$];

    // Shadow of the stack: words, live entry count and capacity register.
    logic [bss_pkg::DATA_W-1:0] stack_words[STACK_DEPTH];
    int cap_setting = 64;
    int live_count = 0;

    // Word pool for the random traffic; repeats make searches hit and give
    // duplicate words so the lowest-index rule matters.
    logic [bss_pkg::DATA_W-1:0] word_pool[8];

    bit jitter_en = 1'b1;   // random idling on both channels
    int failures = 0;
    int requests_done = 0;
    int results_seen = 0;
    int full_pushes = 0;
    int empty_reads = 0;
    int search_hits = 0;
    int search_misses = 0;
    int deepest_hit = 0;
    int holdoff_left = 0;
    int quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predicts the result of one request and moves the shadow state along.
    function automatic t_stack_result apply_request(input t_stack_request req);
        t_stack_result res;
        int limit;
        int k;
        res.status = bss_pkg::STAT_OK;
        res.data = '0;
        res.found_index = '0;
        // capacity above the array size saturates at the array size
        limit = (cap_setting > STACK_DEPTH) ? STACK_DEPTH : cap_setting;
        case (req.op)
            bss_pkg::OP_PUSH: begin
                // also covers capacity zero and capacity lowered below the count
                if (live_count >= limit) begin
                    res.status = bss_pkg::STAT_FULL;
                    full_pushes++;
                end else begin
                    stack_words[live_count] = req.value;
                    live_count++;
                end
            end
            bss_pkg::OP_POP, bss_pkg::OP_PEEK: begin
                if (live_count == 0) begin
                    res.status = bss_pkg::STAT_EMPTY;
                    empty_reads++;
                end else begin
                    res.data = stack_words[live_count-1];
                    if (req.op == bss_pkg::OP_POP) live_count--;
                end
            end
            bss_pkg::OP_CLEAR: live_count = 0;
            bss_pkg::OP_SEARCH: begin
                res.status = bss_pkg::STAT_NOT_FOUND;
                for (k = 0; k < live_count; k++) begin
                    if (stack_words[k] == req.value) begin
                        res.status = bss_pkg::STAT_OK;
                        res.found_index = k[bss_pkg::IDX_OUT_W-1:0];
                        break;
                    end
                end
                if (res.status == bss_pkg::STAT_OK) begin
                    search_hits++;
                    if (k > deepest_hit) deepest_hit = k;
                end else begin
                    search_misses++;
                end
            end
            default: ;  // unused codes leave everything alone
        endcase
        res.count = live_count[bss_pkg::CAP_W-1:0];
        return res;
    endfunction

    function automatic void queue_request(input logic [bss_pkg::OP_W-1:0] op,
                                          input logic [bss_pkg::DATA_W-1:0] value);
        t_stack_request req;
        req.op = op;
        req.value = value;
        pending_requests.push_back(req);
    endfunction

    // Request driver: holds a stalled request, otherwise offers the next
    // pending one unless it idles this cycle.
    always @(posedge i_clk) begin : drive_requests
        t_stack_request nxt;
        t_stack_request taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                taken.op = i_opcode;
                taken.value = i_value;
                owed_results.push_back(apply_request(taken));
                requests_done++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_requests.size() != 0 &&
                    !(jitter_en && $urandom_range(0, 99) < 7)) begin
                    nxt = pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                    i_opcode <= nxt.op;
                    i_value <= nxt.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted result against the oldest owed
    // one, then decides the stall for the next cycle.
    always @(posedge i_clk) begin : check_results
        t_stack_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (owed_results.size() == 0) begin
                    $error("result with nothing owed: status %0d data %0h count %0d",
                           o_status, o_data, o_count);
                    failures++;
                end else begin
                    want = owed_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        failures++;
                    end
                    if (o_data !== want.data) begin
                        $error("data: expected %0h, got %0h", want.data, o_data);
                        failures++;
                    end
                    if (o_found_index !== want.found_index) begin
                        $error("found_index: expected %0d, got %0d",
                               want.found_index, o_found_index);
                        failures++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_count);
                        failures++;
                    end
                end
                // long hold-off so the block backs up and stalls its input
                if (results_seen == HOLDOFF_AT) holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left != 0) begin
                i_out_stall <= 1'b1;
                holdoff_left--;
            end else begin
                i_out_stall <= jitter_en && ($urandom_range(0, 99) < 7);
            end
        end
    end

    // Watchdog on cycles where neither channel moves anything.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Waits until every request went in and every result came back.
    task automatic drain();
        while (pending_requests.size() != 0 || i_in_valid || owed_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Capacity write; only called while the block is idle.
    task automatic write_capacity(input logic [bss_pkg::CAP_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_setting = int'(cap);
        @(negedge i_clk);
    endtask

    // Random traffic as bursts: push runs that fill the stack, pop/peek runs,
    // searches over pool, recent or fresh keys, clears, and raw noise.
    task automatic queue_random_traffic(input int n_items, input int burst_max);
        int made;
        int len;
        int mode;
        int k;
        logic [bss_pkg::DATA_W-1:0] w;
        logic [bss_pkg::DATA_W-1:0] last_word;
        made = 0;
        last_word = $urandom;
        for (k = 0; k < 8; k++) word_pool[k] = $urandom;
        while (made < n_items) begin
            mode = $urandom_range(0, 9);
            if (mode <= 3) begin
                len = $urandom_range(1, burst_max);
                repeat (len) begin
                    w = $urandom_range(0, 1) ? word_pool[$urandom_range(0, 7)] : $urandom;
                    last_word = w;
                    queue_request(bss_pkg::OP_PUSH, w);
                    made++;
                end
            end else if (mode <= 5) begin
                len = $urandom_range(1, (burst_max + 1) / 2);
                repeat (len) begin
                    queue_request($urandom_range(0, 3) == 0 ? bss_pkg::OP_PEEK
                                                            : bss_pkg::OP_POP, $urandom);
                    made++;
                end
            end else if (mode <= 7) begin
                len = $urandom_range(1, 3);
                repeat (len) begin
                    case ($urandom_range(0, 2))
                        0: w = word_pool[$urandom_range(0, 7)];
                        1: w = last_word;
                        default: w = $urandom;
                    endcase
                    queue_request(bss_pkg::OP_SEARCH, w);
                    made++;
                end
            end else if (mode == 8) begin
                queue_request(bss_pkg::OP_W'($urandom_range(0, 7)), $urandom);
                made++;
            end else begin
                queue_request(bss_pkg::OP_CLEAR, $urandom);
                made++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty stack, unused codes, extreme words, duplicates
        queue_request(bss_pkg::OP_POP, 32'h0);
        queue_request(bss_pkg::OP_PEEK, 32'h0);
        queue_request(bss_pkg::OP_SEARCH, 32'h0);
        queue_request(3'd5, 32'hFFFF_FFFF);
        queue_request(3'd6, 32'h8000_0000);
        queue_request(3'd7, 32'h7FFF_FFFF);
        queue_request(bss_pkg::OP_PUSH, 32'h7FFF_FFFF);
        queue_request(bss_pkg::OP_PUSH, 32'h8000_0000);
        queue_request(bss_pkg::OP_PUSH, 32'h0);
        queue_request(bss_pkg::OP_PUSH, 32'h8000_0000);
        queue_request(bss_pkg::OP_PUSH, 32'hFFFF_FFFF);
        queue_request(bss_pkg::OP_PEEK, 32'h0);
        queue_request(bss_pkg::OP_SEARCH, 32'h8000_0000);   // duplicate: lowest wins
        queue_request(bss_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        queue_request(bss_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        queue_request(bss_pkg::OP_SEARCH, 32'h1234_5678);   // miss over live entries
        queue_request(bss_pkg::OP_POP, 32'h0);
        queue_request(bss_pkg::OP_POP, 32'h0);
        queue_request(bss_pkg::OP_CLEAR, 32'h0);
        queue_request(bss_pkg::OP_POP, 32'h0);
        queue_request(bss_pkg::OP_SEARCH, 32'h7FFF_FFFF);   // stale word after clear
        queue_request(bss_pkg::OP_PUSH, 32'h1);
        drain();

        write_capacity(7'd3);
        queue_random_traffic(120, 7);
        drain();

        // full size; the long hold-off falls in this phase
        write_capacity(7'd64);
        queue_random_traffic(200, 68);
        drain();

        write_capacity(7'd1);
        queue_random_traffic(80, 3);
        drain();

        // capacity zero: every push reports full
        write_capacity(7'd0);
        queue_random_traffic(50, 3);
        drain();

        // above the array size with no idling at all, ending well filled
        jitter_en = 1'b0;
        write_capacity(7'd127);
        queue_random_traffic(200, 68);
        repeat (30) queue_request(bss_pkg::OP_PUSH, $urandom);
        drain();

        // capacity dropped below the live count
        jitter_en = 1'b1;
        write_capacity(7'd8);
        queue_random_traffic(100, 12);
        drain();

        $display("Covered %0d requests / %0d results at capacities 64,3,64,1,0,127,8.",
                 requests_done, results_seen);
        $display("Full pushes %0d, empty reads %0d, search hits %0d (deepest %0d), misses %0d.",
                 full_pushes, empty_reads, search_hits, deepest_hit, search_misses);
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
